// ===== rtl/tcw_pkg.sv =====
package tcw_pkg;

    localparam int ROWS_DEFAULT = 25;
    localparam int COLS_DEFAULT = 80;

    localparam int FUNC_W = 2;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;

    localparam logic [FUNC_W-1:0] FUNC_PRINT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

    localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
    localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
    localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h0F;

    typedef struct packed {
        logic load_item;
        logic print;
        logic rd_issue;
        logic cap_cell;
        logic cnt_clr;
        logic fill_run;
        logic fill_rst_attr;
        logic scroll_run;
        logic home;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              will_scroll;
        logic              rd_in_range;
        logic              fill_last;
        logic              scroll_last;
        logic              out_free;
    } t_stat;

endpackage

// ===== rtl/tcw_ctrl.sv =====
module tcw_ctrl import tcw_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_DECODE,
        S_READ,
        S_CLEAR,
        S_SCROLL,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_ready;
    logic   n_ready;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_INIT: begin
                o_cmd.fill_run      = 1'b1;
                o_cmd.fill_rst_attr = 1'b1;
                if (i_stat.fill_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid && r_ready) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_stat.func)
                    FUNC_PRINT: begin
                        o_cmd.print   = 1'b1;
                        o_cmd.cnt_clr = 1'b1;
                        n_state       = i_stat.will_scroll ? S_SCROLL : S_FINISH;
                    end
                    FUNC_CLEAR: begin
                        o_cmd.cnt_clr = 1'b1;
                        o_cmd.home    = 1'b1;
                        n_state       = S_CLEAR;
                    end
                    FUNC_READ: begin
                        o_cmd.rd_issue = i_stat.rd_in_range;
                        n_state        = i_stat.rd_in_range ? S_READ : S_FINISH;
                    end
                    default: begin
                        n_state = S_FINISH;
                    end
                endcase
            end
            S_READ: begin
                o_cmd.cap_cell = 1'b1;
                n_state        = S_FINISH;
            end
            S_CLEAR: begin
                o_cmd.fill_run = 1'b1;
                if (i_stat.fill_last) begin
                    n_state = S_FINISH;
                end
            end
            S_SCROLL: begin
                o_cmd.scroll_run = 1'b1;
                if (i_stat.scroll_last) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
        n_ready = (n_state == S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= n_ready;
        end
    end

    assign o_ready = r_ready;

endmodule

// ===== rtl/tcw_datapath.sv =====
module tcw_datapath import tcw_pkg::*; #(
    parameter int ROWS = ROWS_DEFAULT,
    parameter int COLS = COLS_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [FUNC_W-1:0] i_func,
    input  logic [CHAR_W-1:0] i_char_code,
    input  logic [ROW_W-1:0]  i_read_row,
    input  logic [COL_W-1:0]  i_read_col,
    input  logic              i_cfg_valid,
    input  logic [ATTR_W-1:0] i_cfg_data,
    input  logic              i_ready,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    output logic              o_valid,
    output logic [ROW_W-1:0]  o_cur_row,
    output logic [COL_W-1:0]  o_cur_col,
    output logic              o_did_scroll,
    output logic [CHAR_W-1:0] o_cell_char,
    output logic [ATTR_W-1:0] o_cell_attr
);

    localparam int TOTAL  = ROWS * COLS;
    localparam int SHIFTN = (ROWS - 1) * COLS;
    localparam int AW     = $clog2(TOTAL);
    localparam int RW     = $clog2(ROWS);
    localparam int CW     = $clog2(COLS);
    localparam int CNTW   = $clog2(TOTAL + 1);
    localparam logic [AW-1:0] COLS_A = AW'(COLS);

    logic [ATTR_W+CHAR_W-1:0] mem [TOTAL];
    logic [ATTR_W+CHAR_W-1:0] r_rd_data;

    logic [ATTR_W-1:0] r_attr;
    logic [RW-1:0]     r_row;
    logic [CW-1:0]     r_col;
    logic [FUNC_W-1:0] r_func;
    logic [CHAR_W-1:0] r_char;
    logic [ROW_W-1:0]  r_rr;
    logic [COL_W-1:0]  r_rc;
    logic              r_scroll;
    logic [CHAR_W-1:0] r_cell_char;
    logic [ATTR_W-1:0] r_cell_attr;
    logic [CNTW-1:0]   r_cnt;

    logic              r_out_valid;
    logic [ROW_W-1:0]  r_out_row;
    logic [COL_W-1:0]  r_out_col;
    logic              r_out_scroll;
    logic [CHAR_W-1:0] r_out_char;
    logic [ATTR_W-1:0] r_out_attr;

    logic                     col_last;
    logic                     row_last;
    logic                     newline;
    logic                     wrap;
    logic [AW-1:0]            cur_addr;
    logic [AW-1:0]            item_addr;
    logic [CNTW-1:0]          w_idx;
    logic                     w_copy;
    logic [ATTR_W-1:0]        fill_attr;
    logic                     we;
    logic [AW-1:0]            waddr;
    logic [ATTR_W+CHAR_W-1:0] wdata;
    logic                     re;
    logic [AW-1:0]            raddr;

    assign col_last  = (r_col == CW'(COLS - 1));
    assign row_last  = (r_row == RW'(ROWS - 1));
    assign newline   = (r_char == NEWLINE_CHAR);
    assign wrap      = newline || col_last;
    assign cur_addr  = AW'(r_row) * COLS_A + AW'(r_col);
    assign item_addr = AW'(r_rr) * COLS_A + AW'(r_rc);
    assign w_idx     = r_cnt - CNTW'(1);
    assign w_copy    = (w_idx < CNTW'(SHIFTN));
    assign fill_attr = i_cmd.fill_rst_attr ? RESET_ATTR : r_attr;

    always_comb begin
        o_stat.func        = r_func;
        o_stat.will_scroll = row_last && wrap;
        o_stat.rd_in_range = (int'(r_rr) < ROWS) && (int'(r_rc) < COLS);
        o_stat.fill_last   = (r_cnt == CNTW'(TOTAL - 1));
        o_stat.scroll_last = (r_cnt == CNTW'(TOTAL));
        o_stat.out_free    = !r_out_valid || i_ready;
    end

    always_comb begin
        we    = 1'b0;
        waddr = '0;
        wdata = '0;
        if (i_cmd.print && !newline) begin
            we    = 1'b1;
            waddr = cur_addr;
            wdata = {r_attr, r_char};
        end else if (i_cmd.fill_run) begin
            we    = 1'b1;
            waddr = AW'(r_cnt);
            wdata = {fill_attr, BLANK_CHAR};
        end else if (i_cmd.scroll_run && (r_cnt != '0)) begin
            we    = 1'b1;
            waddr = AW'(w_idx);
            wdata = w_copy ? r_rd_data : {r_attr, BLANK_CHAR};
        end
    end

    always_comb begin
        re    = 1'b0;
        raddr = '0;
        if (i_cmd.rd_issue) begin
            re    = 1'b1;
            raddr = item_addr;
        end else if (i_cmd.scroll_run && (r_cnt < CNTW'(SHIFTN))) begin
            re    = 1'b1;
            raddr = AW'(r_cnt + CNTW'(COLS));
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (re) begin
            r_rd_data <= mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr      <= RESET_ATTR;
            r_row       <= '0;
            r_col       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_attr <= i_cfg_data;
            end
            if (i_cmd.home) begin
                r_row <= '0;
                r_col <= '0;
            end else if (i_cmd.print) begin
                if (wrap) begin
                    r_col <= '0;
                    if (!row_last) begin
                        r_row <= r_row + RW'(1);
                    end
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
            if (i_cmd.cnt_clr) begin
                r_cnt <= '0;
            end else if (i_cmd.fill_run || i_cmd.scroll_run) begin
                r_cnt <= r_cnt + CNTW'(1);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_func      <= i_func;
            r_char      <= i_char_code;
            r_rr        <= i_read_row;
            r_rc        <= i_read_col;
            r_scroll    <= 1'b0;
            r_cell_char <= '0;
            r_cell_attr <= '0;
        end else begin
            if (i_cmd.print && o_stat.will_scroll) begin
                r_scroll <= 1'b1;
            end
            if (i_cmd.cap_cell) begin
                r_cell_char <= r_rd_data[CHAR_W-1:0];
                r_cell_attr <= r_rd_data[ATTR_W+CHAR_W-1:CHAR_W];
            end
        end
        if (i_cmd.load_out) begin
            r_out_row    <= ROW_W'(r_row);
            r_out_col    <= COL_W'(r_col);
            r_out_scroll <= r_scroll;
            r_out_char   <= r_cell_char;
            r_out_attr   <= r_cell_attr;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_cur_row    = r_out_row;
    assign o_cur_col    = r_out_col;
    assign o_did_scroll = r_out_scroll;
    assign o_cell_char  = r_out_char;
    assign o_cell_attr  = r_out_attr;

endmodule

// ===== rtl/text_console_writer.sv =====
// Channel   Handshake                  Word
// input     i_valid / o_ready          i_func, i_char_code, i_read_row, i_read_col
// output    o_valid / i_ready          o_cur_row, o_cur_col, o_did_scroll,
//                                      o_cell_char, o_cell_attr
// config    i_cfg_valid / o_cfg_ready  i_cfg_data (text attribute)
//
// One word is worked on at a time by the controller. A clear and a scrolling print
// pass over every cell, paced by the single write and single read port of the cell
// memory. After reset a clearing pass fills the memory, with ready low.
// A finished result waits in the output register while the next word is accepted;
// a second result stalls in the controller until the output register frees.
module text_console_writer import tcw_pkg::*; #(
    parameter int ROWS = ROWS_DEFAULT,
    parameter int COLS = COLS_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [FUNC_W-1:0] i_func,
    input  logic [CHAR_W-1:0] i_char_code,
    input  logic [ROW_W-1:0]  i_read_row,
    input  logic [COL_W-1:0]  i_read_col,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [ROW_W-1:0]  o_cur_row,
    output logic [COL_W-1:0]  o_cur_col,
    output logic              o_did_scroll,
    output logic [CHAR_W-1:0] o_cell_char,
    output logic [ATTR_W-1:0] o_cell_attr,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [ATTR_W-1:0] i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    tcw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    tcw_datapath #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_func       (i_func),
        .i_char_code  (i_char_code),
        .i_read_row   (i_read_row),
        .i_read_col   (i_read_col),
        .i_cfg_valid  (i_cfg_valid && o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_ready      (i_ready),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_valid      (o_valid),
        .o_cur_row    (o_cur_row),
        .o_cur_col    (o_cur_col),
        .o_did_scroll (o_did_scroll),
        .o_cell_char  (o_cell_char),
        .o_cell_attr  (o_cell_attr)
    );

`ifndef SYNTHESIS
    a_accept_drops_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("ready stayed high after a word was accepted");

    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (int'(o_cur_col) < COLS))
        else $error("cursor column beyond the last column");

    a_scroll_bottom_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_did_scroll) |-> (o_cur_row == ROW_W'(ROWS - 1)))
        else $error("scrolled result without the cursor on the last row");

    a_scroll_no_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_did_scroll) |-> (o_cell_char == '0 && o_cell_attr == '0))
        else $error("scrolled result carries cell data");
`endif

endmodule

// ===== bench/text_console_writer_tb.sv =====
module text_console_writer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    localparam int ROWS  = ROWS_DEFAULT;
    localparam int COLS  = COLS_DEFAULT;
    localparam int CELLS = ROWS * COLS;
    localparam int WORDS_PER_PHASE = 445;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic              scroll;
        logic [CHAR_W-1:0] ch;
        logic [ATTR_W-1:0] at;
    } t_console_result;

    // Shadow copy of the screen, cursor and attribute, plus the queue of
    // cursor and cell words that the block still owes.
    class screen_shadow;
        logic [15:0]       cells [CELLS];
        int unsigned       cur_r;
        int unsigned       cur_c;
        logic [ATTR_W-1:0] attr;
        t_console_result   due_results [$];
        int                errors;
        int                checked;
        int                scrolls;
        int                clears;
        int                reads;

        function new();
            fill(RESET_ATTR);
            cur_r   = 0;
            cur_c   = 0;
            attr    = RESET_ATTR;
            errors  = 0;
            checked = 0;
            scrolls = 0;
            clears  = 0;
            reads   = 0;
        endfunction

        function void fill(logic [ATTR_W-1:0] a);
            for (int i = 0; i < CELLS; i++) cells[i] = {a, BLANK_CHAR};
        endfunction

        function void take_word(logic [FUNC_W-1:0] func, logic [CHAR_W-1:0] ch,
                                logic [ROW_W-1:0] rr, logic [COL_W-1:0] rc);
            t_console_result r;
            r = '0;
            case (func)
                FUNC_PRINT: begin
                    if (ch == NEWLINE_CHAR) begin
                        cur_r++;
                        cur_c = 0;
                    end else begin
                        cells[cur_r * COLS + cur_c] = {attr, ch};
                        cur_c++;
                        if (cur_c >= COLS) begin
                            cur_c = 0;
                            cur_r++;
                        end
                    end
                    if (cur_r >= ROWS) begin
                        for (int i = 0; i < (ROWS - 1) * COLS; i++) cells[i] = cells[i + COLS];
                        for (int i = (ROWS - 1) * COLS; i < CELLS; i++)
                            cells[i] = {attr, BLANK_CHAR};
                        cur_r    = ROWS - 1;
                        r.scroll = 1'b1;
                        scrolls++;
                    end
                end
                FUNC_CLEAR: begin
                    fill(attr);
                    cur_r = 0;
                    cur_c = 0;
                    clears++;
                end
                FUNC_READ: begin
                    if (rr < ROWS && rc < COLS) {r.at, r.ch} = cells[rr * COLS + rc];
                    reads++;
                end
                default: ;
            endcase
            r.row = cur_r[ROW_W-1:0];
            r.col = cur_c[COL_W-1:0];
            due_results.push_back(r);
        endfunction

        task report(string what);
            errors++;
            $display("MISMATCH: %s", what);
        endtask

        task check_word(t_console_result got);
            t_console_result want;
            if (due_results.size() == 0) begin
                report($sformatf("result row %0d col %0d with nothing outstanding",
                                 got.row, got.col));
                return;
            end
            want = due_results.pop_front();
            checked++;
            if (got.row !== want.row)
                report($sformatf("result %0d cur_row %0d, want %0d", checked, got.row, want.row));
            if (got.col !== want.col)
                report($sformatf("result %0d cur_col %0d, want %0d", checked, got.col, want.col));
            if (got.scroll !== want.scroll)
                report($sformatf("result %0d did_scroll %0b, want %0b", checked, got.scroll,
                                 want.scroll));
            if (got.ch !== want.ch)
                report($sformatf("result %0d cell_char %h, want %h", checked, got.ch, want.ch));
            if (got.at !== want.at)
                report($sformatf("result %0d cell_attr %h, want %h", checked, got.at, want.at));
        endtask
    endclass

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_valid     = 1'b0;
    logic              o_ready;
    logic [FUNC_W-1:0] i_func      = '0;
    logic [CHAR_W-1:0] i_char_code = '0;
    logic [ROW_W-1:0]  i_read_row  = '0;
    logic [COL_W-1:0]  i_read_col  = '0;
    logic              o_valid;
    logic              i_ready     = 1'b0;
    logic [ROW_W-1:0]  o_cur_row;
    logic [COL_W-1:0]  o_cur_col;
    logic              o_did_scroll;
    logic [CHAR_W-1:0] o_cell_char;
    logic [ATTR_W-1:0] o_cell_attr;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [ATTR_W-1:0] i_cfg_data  = '0;

    screen_shadow sb;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int words_sent     = 0;
    int cfg_writes     = 0;

    text_console_writer #(
        .ROWS(ROWS),
        .COLS(COLS)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_func      (i_func),
        .i_char_code (i_char_code),
        .i_read_row  (i_read_row),
        .i_read_col  (i_read_col),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_cur_row   (o_cur_row),
        .o_cur_col   (o_cur_col),
        .o_did_scroll(o_did_scroll),
        .o_cell_char (o_cell_char),
        .o_cell_attr (o_cell_attr),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_ready = ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_word({o_cur_row, o_cur_col, o_did_scroll, o_cell_char, o_cell_attr});
    end

    // Called at a falling edge; returns at the falling edge after acceptance
    // with valid still high, so a following word can go out back to back.
    task send_word(logic [FUNC_W-1:0] func, logic [CHAR_W-1:0] ch,
                   logic [ROW_W-1:0] rr, logic [COL_W-1:0] rc);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid     = 1'b1;
        i_func      = func;
        i_char_code = ch;
        i_read_row  = rr;
        i_read_col  = rc;
        do @(posedge i_clk); while (!o_ready);
        sb.take_word(func, ch, rr, rc);
        words_sent++;
        @(negedge i_clk);
    endtask

    task wait_drained();
        i_valid = 1'b0;
        while (sb.due_results.size() != 0) @(negedge i_clk);
    endtask

    task write_attr(logic [ATTR_W-1:0] value);
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.attr = value;
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task directed_words();
        send_word(FUNC_READ, 8'h00, 5'd0, 7'd0);
        send_word(FUNC_READ, 8'hFF, ROW_W'(ROWS - 1), COL_W'(COLS - 1));
        send_word(FUNC_PRINT, 8'h00, 5'd0, 7'd0);
        send_word(FUNC_PRINT, 8'hFF, 5'h1F, 7'h7F);
        send_word(FUNC_PRINT, 8'h41, 5'd0, 7'd0);
        send_word(FUNC_READ, 8'h00, 5'd0, 7'd0);
        send_word(FUNC_READ, 8'h00, 5'd0, 7'd1);
        send_word(FUNC_PRINT, NEWLINE_CHAR, 5'd0, 7'd0);
        send_word(FUNC_UNUSED, 8'hFF, 5'h1F, 7'h7F);
        send_word(FUNC_READ, 8'h00, ROW_W'(ROWS), 7'd0);
        send_word(FUNC_READ, 8'h00, 5'd0, COL_W'(COLS));
        send_word(FUNC_READ, 8'h00, 5'h1F, 7'h7F);
        send_word(FUNC_PRINT, BLANK_CHAR, 5'd0, 7'd0);
        send_word(FUNC_READ, 8'h00, 5'd1, 7'd0);
        send_word(FUNC_CLEAR, 8'hFF, 5'h1F, 7'h7F);
        send_word(FUNC_READ, 8'h00, 5'd0, 7'd0);
        send_word(FUNC_READ, 8'h00, 5'd0, 7'd1);
    endtask

    // Mostly prints of random bytes, with reads often near the cursor; runs of newlines
    // push the cursor to the bottom so that scrolling gets exercised.
    task run_random(int count);
        int               sent;
        int               r;
        int               k;
        int               n;
        bit               paused;
        logic [ROW_W-1:0] rr;
        logic [COL_W-1:0] rc;
        sent   = 0;
        paused = 0;
        while (sent < count) begin
            if (!paused && sent >= count / 2) begin
                wait_drained();
                paused = 1;
            end
            r  = $urandom_range(999);
            rr = ROW_W'($urandom);
            rc = COL_W'($urandom);
            if (r < 6) begin
                send_word(FUNC_CLEAR, CHAR_W'($urandom), rr, rc);
            end else if (r < 14) begin
                send_word(FUNC_UNUSED, CHAR_W'($urandom), rr, rc);
            end else if (r < 170) begin
                k = $urandom_range(9);
                if (k < 5) begin
                    if (sb.cur_r > 0 && $urandom_range(1) == 1)
                        rr = ROW_W'(sb.cur_r - 1);
                    else
                        rr = ROW_W'(sb.cur_r);
                    rc = COL_W'($urandom_range(COLS - 1));
                end else if (k < 8) begin
                    rr = ROW_W'($urandom_range(ROWS - 1));
                    rc = COL_W'($urandom_range(COLS - 1));
                end
                send_word(FUNC_READ, CHAR_W'($urandom), rr, rc);
            end else if (r < 176) begin
                n = $urandom_range(28, 5);
                repeat (n) send_word(FUNC_PRINT, NEWLINE_CHAR, rr, rc);
                sent += n - 1;
            end else begin
                send_word(FUNC_PRINT, ($urandom_range(15) == 0) ? NEWLINE_CHAR : 8'($urandom),
                          rr, rc);
            end
            sent++;
        end
    endtask

    initial begin
        #200_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        logic [ATTR_W-1:0] attrs [4];
        sb = new();
        attrs[0] = 8'hFF;
        attrs[1] = 8'h00;
        attrs[2] = 8'($urandom_range(254, 1));
        attrs[3] = 8'($urandom);
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        directed_words();
        for (int ph = 0; ph < 4; ph++) begin
            wait_drained();
            write_attr(attrs[ph]);
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            run_random(WORDS_PER_PHASE);
        end
        wait_drained();
        repeat (CELLS + 10) @(negedge i_clk);

        $display("Sent %0d words under four pacing mixes and %0d attribute writes.",
                 words_sent, cfg_writes);
        $display("Checked %0d results: %0d reads, %0d clears, %0d scrolls, %0d mismatches.",
                 sb.checked, sb.reads, sb.clears, sb.scrolls, sb.errors);
        if (sb.errors == 0 && sb.due_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
